// ===== src/ols_pkg.sv =====
// Shared types and constants for the ordered list store.
// No dependencies; every other file of the block refers to this package.
package ols_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int VAL_W     = 32;
	localparam int CNT_OUT_W = 7;

	typedef enum logic [2:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_POP_BACK   = 3'd2,
		REQ_POP_FRONT  = 3'd3,
		REQ_INSERT     = 3'd4,
		REQ_ERASE      = 3'd5,
		REQ_AVERAGE    = 3'd6,
		REQ_QUERY      = 3'd7
	} req_e;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} stat_e;

	typedef enum logic [1:0] {
		WALK_RIGHT = 2'd0,
		WALK_LEFT  = 2'd1,
		WALK_ERASE = 2'd2,
		WALK_SUM   = 2'd3
	} walk_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOP,
		ST_PROC,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_PLACE,
		ST_FRD,
		ST_BRD,
		ST_BCAP,
		ST_OUT
	} state_t;

endpackage

// ===== src/ols_req_if.sv =====
// Request channel of the ordered list store: valid, ready and one request word.
// Depends on ols_pkg for the value width.
interface ols_req_if;
	logic                              valid;
	logic                              ready;
	logic [2:0]                        req_type;
	logic signed [ols_pkg::VAL_W-1:0]  item_value;
	logic [7:0]                        slot_position;

	modport source (output valid, req_type, item_value, slot_position, input ready);
	modport sink   (input valid, req_type, item_value, slot_position, output ready);
endinterface

// ===== src/ols_rsp_if.sv =====
// Result channel of the ordered list store: valid, ready and one result word.
// Depends on ols_pkg for the value and count widths.
interface ols_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ols_pkg::VAL_W-1:0]     front_value;
	logic signed [ols_pkg::VAL_W-1:0]     back_value;
	logic [ols_pkg::CNT_OUT_W-1:0]        entry_count;
	logic [1:0]                           status;

	modport source (output valid, front_value, back_value, entry_count, status, input ready);
	modport sink   (input valid, front_value, back_value, entry_count, status, output ready);
endinterface

// ===== src/ordered_list_store.sv =====
// Top level of the ordered list store: request sequencer, entry memory and divider.
// Depends on ols_pkg, ols_req_if, ols_rsp_if, ols_mem and ols_div.
//
// The block holds an ordered list of up to DEPTH signed 32-bit values. A word on the
// req channel asks for one of eight operations: push at the back or front, pop at the
// back or front, insert at a clamped position, erase every match of a value, append
// the truncated average, or query. Each request produces exactly one word on the rsp
// channel with the front value, back value, count and status after the operation.
// The block takes one request at a time: req.ready is high only while it is idle.
// Operations that move entries walk the memory through its single read port, one
// entry at a time: a front push or an insert shifts the entries from the position to
// the back, a front pop shifts the remaining entries forward, an erase compacts every
// entry, and an average sums every entry and then runs the divider.
// A result word stays on rsp until the receiver takes it; no new request is accepted
// meanwhile. Reset empties the list at once; entry contents are not cleared, and
// values read while the list is empty are shown as zero on rsp.
module ordered_list_store #(
	parameter int DEPTH = ols_pkg::DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	ols_req_if.sink  req,
	ols_rsp_if.source rsp
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = ols_pkg::VAL_W + CW;
	localparam int VW = ols_pkg::VAL_W;

	ols_pkg::state_t state_q, state_d;
	ols_pkg::walk_t  kind_q;
	ols_pkg::stat_e  status_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   i_q;
	logic [CW-1:0]   w_q;
	logic [CW-1:0]   pos_q;
	logic [VW-1:0]   val_q;
	logic signed [SW-1:0] sum_q;
	logic [VW-1:0]   front_q;
	logic [VW-1:0]   back_q;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [VW-1:0]   mem_wdata;
	logic [AW-1:0]   mem_raddr;
	logic [VW-1:0]   mem_rdata;
	logic            div_start;
	logic            div_done;
	logic [VW-1:0]   div_quot;

	logic            accept;
	logic            full;
	logic            empty;
	logic [CW-1:0]   ins_pos;
	logic [CW-1:0]   i_plus;
	logic [CW-1:0]   i_minus;
	logic [31:0]     cnt_ext;

	assign accept  = req.valid && req.ready;
	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign i_plus  = i_q + 1'b1;
	assign i_minus = i_q - 1'b1;
	assign ins_pos = (32'(req.slot_position) >= 32'(count_q)) ? count_q
		: CW'(req.slot_position);

	ols_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

	ols_div #(.SW(SW), .CW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Next state and memory port control.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = i_q[AW-1:0];
		mem_wdata = mem_rdata;
		mem_raddr = i_q[AW-1:0];
		div_start = 1'b0;
		case (state_q)
			ols_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = ols_pkg::ST_FRD;
					case (ols_pkg::req_e'(req.req_type))
						ols_pkg::REQ_PUSH_BACK,
						ols_pkg::REQ_PUSH_FRONT,
						ols_pkg::REQ_INSERT: begin
							if (!full) begin
								state_d = ols_pkg::ST_LOOP;
							end
						end
						ols_pkg::REQ_POP_FRONT: begin
							if (!empty) begin
								state_d = ols_pkg::ST_LOOP;
							end
						end
						ols_pkg::REQ_ERASE: state_d = ols_pkg::ST_LOOP;
						ols_pkg::REQ_AVERAGE: begin
							if (!empty && !full) begin
								state_d = ols_pkg::ST_LOOP;
							end
						end
						default: state_d = ols_pkg::ST_FRD;
					endcase
				end
			end
			ols_pkg::ST_LOOP: begin
				case (kind_q)
					ols_pkg::WALK_RIGHT: begin
						mem_raddr = i_minus[AW-1:0];
						state_d   = (i_q > pos_q) ? ols_pkg::ST_PROC : ols_pkg::ST_PLACE;
					end
					ols_pkg::WALK_LEFT: begin
						mem_raddr = i_plus[AW-1:0];
						state_d   = (i_plus < count_q) ? ols_pkg::ST_PROC : ols_pkg::ST_FRD;
					end
					ols_pkg::WALK_ERASE: begin
						state_d = (i_q < count_q) ? ols_pkg::ST_PROC : ols_pkg::ST_FRD;
					end
					default: begin
						state_d = (i_q < count_q) ? ols_pkg::ST_PROC : ols_pkg::ST_DIV_GO;
					end
				endcase
			end
			ols_pkg::ST_PROC: begin
				state_d = ols_pkg::ST_LOOP;
				case (kind_q)
					ols_pkg::WALK_RIGHT,
					ols_pkg::WALK_LEFT: mem_we = 1'b1;
					ols_pkg::WALK_ERASE: begin
						mem_we    = mem_rdata != val_q;
						mem_waddr = w_q[AW-1:0];
					end
					default: mem_we = 1'b0;
				endcase
			end
			ols_pkg::ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ols_pkg::ST_DIV_WAIT;
			end
			ols_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = ols_pkg::ST_PLACE;
				end
			end
			ols_pkg::ST_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[AW-1:0];
				mem_wdata = val_q;
				state_d   = ols_pkg::ST_FRD;
			end
			ols_pkg::ST_FRD: begin
				mem_raddr = '0;
				state_d   = ols_pkg::ST_BRD;
			end
			ols_pkg::ST_BRD: begin
				mem_raddr = AW'(count_q - 1'b1);
				state_d   = ols_pkg::ST_BCAP;
			end
			ols_pkg::ST_BCAP: state_d = ols_pkg::ST_OUT;
			ols_pkg::ST_OUT: begin
				if (rsp.ready) begin
					state_d = ols_pkg::ST_IDLE;
				end
			end
			default: state_d = ols_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ols_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ols_pkg::ST_IDLE: begin
					if (accept && !empty
						&& ols_pkg::req_e'(req.req_type) == ols_pkg::REQ_POP_BACK) begin
						count_q <= count_q - 1'b1;
					end
				end
				ols_pkg::ST_LOOP: begin
					if (kind_q == ols_pkg::WALK_LEFT && !(i_plus < count_q)) begin
						count_q <= count_q - 1'b1;
					end
					if (kind_q == ols_pkg::WALK_ERASE && !(i_q < count_q)) begin
						count_q <= w_q;
					end
				end
				ols_pkg::ST_PLACE: count_q <= count_q + 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Working registers of the walk; they carry no control meaning while idle.
	always_ff @(posedge clk) begin
		case (state_q)
			ols_pkg::ST_IDLE: begin
				if (accept) begin
					val_q    <= req.item_value;
					i_q      <= count_q;
					w_q      <= '0;
					sum_q    <= '0;
					kind_q   <= ols_pkg::WALK_RIGHT;
					pos_q    <= count_q;
					status_q <= ols_pkg::STAT_OK;
					case (ols_pkg::req_e'(req.req_type))
						ols_pkg::REQ_PUSH_BACK: begin
							if (full) status_q <= ols_pkg::STAT_FULL;
						end
						ols_pkg::REQ_PUSH_FRONT: begin
							pos_q <= '0;
							if (full) status_q <= ols_pkg::STAT_FULL;
						end
						ols_pkg::REQ_INSERT: begin
							pos_q <= ins_pos;
							if (full) status_q <= ols_pkg::STAT_FULL;
						end
						ols_pkg::REQ_POP_BACK: begin
							if (empty) status_q <= ols_pkg::STAT_EMPTY;
						end
						ols_pkg::REQ_POP_FRONT: begin
							i_q    <= '0;
							kind_q <= ols_pkg::WALK_LEFT;
							if (empty) status_q <= ols_pkg::STAT_EMPTY;
						end
						ols_pkg::REQ_ERASE: begin
							i_q    <= '0;
							kind_q <= ols_pkg::WALK_ERASE;
						end
						ols_pkg::REQ_AVERAGE: begin
							i_q    <= '0;
							kind_q <= ols_pkg::WALK_SUM;
							if (empty) begin
								status_q <= ols_pkg::STAT_EMPTY;
							end else if (full) begin
								status_q <= ols_pkg::STAT_FULL;
							end
						end
						default: status_q <= ols_pkg::STAT_OK;
					endcase
				end
			end
			ols_pkg::ST_PROC: begin
				case (kind_q)
					ols_pkg::WALK_RIGHT: i_q <= i_minus;
					ols_pkg::WALK_LEFT:  i_q <= i_plus;
					ols_pkg::WALK_ERASE: begin
						i_q <= i_plus;
						if (mem_rdata != val_q) w_q <= w_q + 1'b1;
					end
					default: begin
						i_q   <= i_plus;
						sum_q <= sum_q + {{CW{mem_rdata[VW-1]}}, mem_rdata};
					end
				endcase
			end
			ols_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					val_q  <= div_quot;
					pos_q  <= count_q;
					kind_q <= ols_pkg::WALK_RIGHT;
				end
			end
			ols_pkg::ST_BRD:  front_q <= mem_rdata;
			ols_pkg::ST_BCAP: back_q  <= mem_rdata;
			default: val_q <= val_q;
		endcase
	end

	assign cnt_ext         = 32'(count_q);
	assign req.ready       = state_q == ols_pkg::ST_IDLE;
	assign rsp.valid       = state_q == ols_pkg::ST_OUT;
	assign rsp.front_value = empty ? '0 : front_q;
	assign rsp.back_value  = empty ? '0 : back_q;
	assign rsp.entry_count = cnt_ext[ols_pkg::CNT_OUT_W-1:0];
	assign rsp.status      = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds capacity");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("request taken while a result is pending");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ols_pkg::ST_DIV_WAIT)
		else $error("divider finished outside its wait state");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ols_pkg::ST_OUT |=> $stable(count_q))
		else $error("count changed while a result was held");
endmodule

// ===== src/ols_mem.sv =====
// Entry storage of the ordered list store: one write port, one registered read port.
// Depends on ols_pkg for the value width.
module ols_mem #(
	parameter int DEPTH = ols_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [ols_pkg::VAL_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [ols_pkg::VAL_W-1:0] rdata_q
);
	logic [ols_pkg::VAL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end
endmodule

// ===== src/ols_div.sv =====
// Restoring divider of the ordered list store: signed sum over unsigned count,
// one quotient bit per cycle, truncated toward zero. Depends on ols_pkg.
module ols_div #(
	parameter int SW = 40,
	parameter int CW = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [SW-1:0]      dividend,
	input  logic [CW-1:0]             divisor,
	output logic                      done,
	output logic [ols_pkg::VAL_W-1:0] quotient
);
	localparam int NW = $clog2(SW + 1);

	logic          busy_q;
	logic          done_q;
	logic          neg_q;
	logic [NW-1:0] cnt_q;
	logic [CW:0]   rem_q;
	logic [SW-1:0] quo_q;
	logic [SW-1:0] mag;
	logic [CW:0]   trial;
	logic          ge;

	assign mag   = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
	assign trial = {rem_q[CW-1:0], quo_q[SW-1]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SW-1];
			rem_q <= '0;
			quo_q <= mag;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, divisor}) : trial;
			quo_q <= {quo_q[SW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (ols_pkg::VAL_W)'(-quo_q) : quo_q[ols_pkg::VAL_W-1:0];
endmodule
